FILE: rtl/crc32mb_pkg.sv
// crc32mb_pkg: shared types, constants and matrix helpers for the multi-byte crc-32 block
// used by the lanes, the merge stage and the top level; depends on nothing

package crc32mb_pkg;

    localparam int unsigned CRC_W              = 32;
    localparam int unsigned BYTE_W             = 8;
    localparam int unsigned DATA_W             = 64;
    localparam int unsigned CNT_W              = 4;
    localparam int unsigned MAX_BYTES          = 8;
    localparam int unsigned DEF_BYTES_PER_ITEM = 8;
    localparam int unsigned ZM_DEPTH           = MAX_BYTES + 1;
    localparam int unsigned ZM_IDX_W           = $clog2(ZM_DEPTH);

    localparam logic [CRC_W-1:0] CRC_POLY     = 32'h04C11DB7;
    localparam logic [CRC_W-1:0] CRC_POLY_REF = {<<{CRC_POLY}};

    typedef logic [CRC_W-1:0]            t_word;
    typedef logic [CRC_W-1:0][CRC_W-1:0] t_mat;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             first;
        t_word            seed;
    } t_s1_ctl;

    // column j = state with only bit j set, advanced through nbytes zero bytes
    function automatic t_mat zero_mat(input int unsigned nbytes);
        t_mat        m;
        t_word       v;
        int unsigned j;
        int unsigned s;
        for (j = 0; j < CRC_W; j++) begin
            v = t_word'(1) << j;
            for (s = 0; s < nbytes * BYTE_W; s++) begin
                v = (v >> 1) ^ (v[0] ? CRC_POLY_REF : t_word'(0));
            end
            m[j] = v;
        end
        return m;
    endfunction

    function automatic t_word mat_apply(input t_mat m, input t_word x);
        t_word       r;
        int unsigned j;
        r = '0;
        for (j = 0; j < CRC_W; j++) begin
            if (x[j]) begin
                r = r ^ m[j];
            end
        end
        return r;
    endfunction

    localparam t_mat ZERO_MATS [ZM_DEPTH] = '{
        zero_mat(0), zero_mat(1), zero_mat(2), zero_mat(3), zero_mat(4),
        zero_mat(5), zero_mat(6), zero_mat(7), zero_mat(8)
    };

endpackage

FILE: rtl/crc32mb_lane.sv
// crc32mb_lane: one byte lane, registers the crc contribution of its byte
// advanced through its own byte and the bytes after it; uses crc32mb_pkg

module crc32mb_lane import crc32mb_pkg::*; #(
    parameter int unsigned LANE = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [CNT_W-1:0]  i_count,
    output t_word             o_part
);

    logic [CNT_W-1:0] adv_bytes;
    t_word            n_part;
    t_word            r_part;

    assign adv_bytes = i_count - CNT_W'(LANE);

    always_comb begin
        n_part = '0;
        if (i_count > CNT_W'(LANE)) begin
            n_part = mat_apply(ZERO_MATS[adv_bytes[ZM_IDX_W-1:0]],
                               {{(CRC_W-BYTE_W){1'b0}}, i_byte});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_part <= n_part;
        end
    end

    assign o_part = r_part;

endmodule

FILE: rtl/crc32mb_merge.sv
// crc32mb_merge: folds the lane contributions into the running crc and seed,
// holds the result register; uses crc32mb_pkg

module crc32mb_merge import crc32mb_pkg::*; #(
    parameter int unsigned BYTES_PER_ITEM = DEF_BYTES_PER_ITEM
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  t_s1_ctl                        i_ctl,
    input  logic [BYTES_PER_ITEM-1:0][CRC_W-1:0] i_parts,
    output t_word                          o_crc
);

    t_word r_crc;
    t_word r_seed;
    t_word r_out;
    t_word n_crc;
    t_word n_seed;
    t_word base;
    t_word data_sum;

    always_comb begin
        data_sum = '0;
        for (int unsigned k = 0; k < BYTES_PER_ITEM; k++) begin
            data_sum = data_sum ^ i_parts[k];
        end
        base   = i_ctl.first ? i_ctl.seed : r_crc;
        n_seed = i_ctl.first ? i_ctl.seed : r_seed;
        n_crc  = mat_apply(ZERO_MATS[i_ctl.count[ZM_IDX_W-1:0]], base) ^ data_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= '0;
            r_seed <= '0;
        end else if (i_en) begin
            r_crc  <= n_crc;
            r_seed <= n_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_crc ^ n_seed;
        end
    end

    assign o_crc = r_out;

endmodule

FILE: rtl/crc32_reflected_multibyte_top.sv
// crc32_reflected_multibyte_top: reflected crc-32 over up to eight bytes per request
// instantiates crc32mb_lane and crc32mb_merge; uses crc32mb_pkg
//
// input channel: i_valid / o_stall with i_data_bytes, i_byte_count, i_first, i_seed;
// a request is taken at a rising edge with i_valid high and o_stall low
// bytes are absorbed lowest first, count saturates at BYTES_PER_ITEM, zero absorbs none
// i_first loads running crc and stored seed from i_seed before the bytes
// output channel: o_valid / i_stall with o_crc_value = running crc xor stored seed
// one result per request, taken at an edge with o_valid high and i_stall low
// pipeline: two register stages (lane, then merge); a request is registered in the lane
// stage, then merged into the output register that drives o_crc_value
// throughput: one request per cycle while o_stall is low; the running crc
// closes its loop through a count-selected advance matrix in the merge stage
// when i_stall holds, the output register keeps its result and one more request
// waits in the lane stage; o_stall rises only when both are full
// reset (synchronous, active low) empties both stages and clears crc and seed to zero

module crc32_reflected_multibyte_top import crc32mb_pkg::*; #(
    parameter int unsigned BYTES_PER_ITEM = DEF_BYTES_PER_ITEM
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [DATA_W-1:0]  i_data_bytes,
    input  logic [CNT_W-1:0]   i_byte_count,
    input  logic               i_first,
    input  logic [CRC_W-1:0]   i_seed,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CRC_W-1:0]   o_crc_value
);

    logic                                 r_s1_valid;
    logic                                 r_out_valid;
    t_s1_ctl                              r_s1_ctl;
    t_s1_ctl                              n_s1_ctl;
    logic                                 adv_out;
    logic                                 s1_ready;
    logic                                 in_take;
    logic [CNT_W-1:0]                     sat_count;
    logic [BYTES_PER_ITEM-1:0][CRC_W-1:0] parts;

    assign adv_out  = r_s1_valid && (!r_out_valid || !i_stall);
    assign s1_ready = !r_s1_valid || adv_out;
    assign in_take  = i_valid && s1_ready;
    assign o_stall  = !s1_ready;
    assign o_valid  = r_out_valid;

    assign sat_count = (i_byte_count > CNT_W'(BYTES_PER_ITEM)) ?
                       CNT_W'(BYTES_PER_ITEM) : i_byte_count;

    always_comb begin
        n_s1_ctl.count = sat_count;
        n_s1_ctl.first = i_first;
        n_s1_ctl.seed  = i_seed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (adv_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_ctl <= n_s1_ctl;
        end
    end

    for (genvar k = 0; k < BYTES_PER_ITEM; k++) begin : g_lane
        crc32mb_lane #(
            .LANE (k)
        ) u_lane (
            .i_clk   (i_clk),
            .i_en    (in_take),
            .i_byte  (i_data_bytes[BYTE_W*k +: BYTE_W]),
            .i_count (sat_count),
            .o_part  (parts[k])
        );
    end

    crc32mb_merge #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv_out),
        .i_ctl   (r_s1_ctl),
        .i_parts (parts),
        .o_crc   (o_crc_value)
    );

    a_take_fills_s1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_s1_valid)
        else $error("accepted request did not reach the lane stage");

    a_adv_fills_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_out |=> r_out_valid)
        else $error("merged result did not reach the output register");

    a_stall_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("input stalled while the pipeline has room");

    a_out_from_s1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_s1_valid))
        else $error("result appeared without a request in the lane stage");

endmodule

FILE: test/crc32_reflected_multibyte_top_tb.sv
// crc32_reflected_multibyte_top_tb: self-checking bench for the multi-byte reflected crc-32 block
// predicts each result with a bit-serial crc model and checks it against the block output
// depends on crc32mb_pkg and crc32_reflected_multibyte_top

module crc32_reflected_multibyte_top_tb;
    import crc32mb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BYTES_PER_ITEM = DEF_BYTES_PER_ITEM;
    localparam int unsigned CYCLE_LIMIT    = 1000000;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned RANDOM_ITEMS   = 1300;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              first;
        logic [CRC_W-1:0]  seed;
        bit                drain;
    } t_crc_req;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [DATA_W-1:0] i_data_bytes = '0;
    logic [CNT_W-1:0]  i_byte_count = '0;
    logic              i_first = 1'b0;
    logic [CRC_W-1:0]  i_seed = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [CRC_W-1:0]  o_crc_value;

    t_crc_req         req_queue[$];
    logic [CRC_W-1:0] crc_expected[$];

    logic [CRC_W-1:0] crc_run = '0;
    logic [CRC_W-1:0] crc_seed = '0;

    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned n_sent = 0;
    int unsigned n_results = 0;
    int unsigned n_first = 0;
    int unsigned n_zero = 0;
    int unsigned n_sat = 0;
    int unsigned n_full = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned hold_mark = 300;
    int unsigned n_holds = 0;

    crc32_reflected_multibyte_top #(
        .BYTES_PER_ITEM(BYTES_PER_ITEM)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_bytes (i_data_bytes),
        .i_byte_count (i_byte_count),
        .i_first      (i_first),
        .i_seed       (i_seed),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_crc_value  (o_crc_value)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [CRC_W-1:0] crc_shift_byte(input logic [CRC_W-1:0] c,
                                                        input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] v;
        int k;
        v = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (k = 0; k < BYTE_W; k++) begin
            v = (v >> 1) ^ (v[0] ? 32'hEDB88320 : 32'h0);
        end
        return v;
    endfunction

    // advances the running crc and seed, returns the value the block should output
    function automatic logic [CRC_W-1:0] predict_crc(input t_crc_req r);
        int unsigned n;
        int unsigned i;
        n = r.count;
        if (n > BYTES_PER_ITEM) begin
            n = BYTES_PER_ITEM;
            n_sat++;
        end
        if (n == 0) n_zero++;
        if (r.first) begin
            crc_run = r.seed;
            crc_seed = r.seed;
            n_first++;
        end
        for (i = 0; i < n; i++) begin
            crc_run = crc_shift_byte(crc_run, r.data[8*i +: 8]);
        end
        return crc_run ^ crc_seed;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [DATA_W-1:0] rand_data();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [CRC_W-1:0] rand_seed();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    function automatic void add_req(input logic [DATA_W-1:0] d, input int unsigned cnt,
                                    input logic f, input logic [CRC_W-1:0] s,
                                    input bit drain);
        t_crc_req r;
        r.data  = d;
        r.count = cnt[CNT_W-1:0];
        r.first = f;
        r.seed  = s;
        r.drain = drain;
        req_queue.push_back(r);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        logic nv;
        nv = i_valid;
        if (i_valid && !o_stall) begin
            crc_expected.push_back(predict_crc(req_queue[0]));
            void'(req_queue.pop_front());
            n_sent++;
            nv = 1'b0;
            if (hold_left == 0 && ((n_sent / 150) % 3) != 2) begin
                gap_left = pick_gap();
            end
        end
        if (i_rst_n && !nv) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (req_queue.size() > 0 &&
                         !(req_queue[0].drain && crc_expected.size() != 0)) begin
                i_data_bytes <= req_queue[0].data;
                i_byte_count <= req_queue[0].count;
                i_first      <= req_queue[0].first;
                i_seed       <= req_queue[0].seed;
                nv = 1'b1;
            end
        end
        i_valid <= nv;
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        logic ns;
        logic [CRC_W-1:0] want;
        if (o_valid && !i_stall) begin
            if (crc_expected.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, actual %h", $time, o_crc_value);
            end else begin
                want = crc_expected.pop_front();
                if (want !== o_crc_value) begin
                    errors++;
                    $display("%0t: crc_value expected %h actual %h", $time, want, o_crc_value);
                end
            end
            n_results++;
        end
        if (o_stall === 1'b1) n_full++;
        ns = 1'b0;
        if (i_rst_n) begin
            if (hold_left == 0 && n_results >= hold_mark) begin
                hold_left = HOLD_CYCLES;
                hold_mark = hold_mark + 600;
                n_holds++;
            end
            if (hold_left > 0) begin
                hold_left--;
                ns = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                ns = 1'b1;
            end else if (((n_results / 170) % 3) != 1) begin
                stall_left = pick_gap();
            end
        end
        i_stall <= ns;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int unsigned k;
        int unsigned len;
        int unsigned kind;
        int unsigned total;
        int unsigned cnt;

        // continuation straight out of reset
        add_req(64'h0123456789ABCDEF, 8, 1'b0, 32'h0, 1'b0);
        add_req(64'h0, 1, 1'b1, 32'h0, 1'b0);
        add_req('1, 8, 1'b1, 32'hFFFFFFFF, 1'b0);
        add_req('1, 0, 1'b1, 32'hA5A5A5A5, 1'b0);
        add_req(64'hFFFF_0000_FFFF_0000, 0, 1'b0, 32'h0, 1'b0);
        add_req('1, 9, 1'b0, 32'h0, 1'b0);
        add_req(64'h8000_0000_0000_0001, 15, 1'b1, 32'h8000_0001, 1'b0);
        for (k = 1; k <= 8; k++) begin
            add_req(64'hFEDCBA9876543210, k, (k == 1), 32'h1234_5678, 1'b0);
        end
        add_req(64'h0000_0000_0000_BEEF, 2, 1'b1, 32'h0, 1'b0);
        add_req(64'hFFFF_FFFF_FFFF_1234, 2, 1'b0, 32'hFFFFFFFF, 1'b0);
        add_req(64'h5555_5555_5555_5555, 12, 1'b0, 32'h5555_5555, 1'b0);
        add_req(64'hAAAA_AAAA_AAAA_AAAA, 8, 1'b1, 32'hAAAA_AAAA, 1'b1);

        total = 0;
        while (total < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            len  = $urandom_range(1, 20);
            if (kind < 70) begin
                for (k = 0; k < len; k++) begin
                    cnt = (k == len - 1) ? $urandom_range(1, 8) : 8;
                    add_req(rand_data(), cnt, (k == 0), rand_seed(),
                            (k == 0) && ($urandom_range(0, 39) == 0));
                end
            end else if (kind < 85) begin
                for (k = 0; k < len; k++) begin
                    add_req({48'h0, 16'(rand_data())}, 2, (k == 0), rand_seed(), 1'b0);
                end
            end else begin
                for (k = 0; k < len; k++) begin
                    add_req(rand_data(), $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                            rand_seed(), 1'b0);
                end
            end
            total = total + len;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_queue.size() != 0 || crc_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (crc_expected.size() != 0) errors++;

        $display("run: %0d requests, %0d results, %0d buffer starts, %0d empty, %0d saturated",
                 n_sent, n_results, n_first, n_zero, n_sat);
        $display("run: %0d long receiver holds, %0d cycles with the input stalled, %0d cycles",
                 n_holds, n_full, cycles);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/crc32mb_pkg.sv
rtl/crc32mb_lane.sv
rtl/crc32mb_merge.sv
rtl/crc32_reflected_multibyte_top.sv
test/crc32_reflected_multibyte_top_tb.sv
